/* hw/rtl/sdas_pkg.sv */
// Shared types and constants of the dual-converter staleness scheduler.
// Used by sdas_ctrl, sdas_datapath and staleness_dual_adc_scheduler_top; no dependencies.
`timescale 1ns / 1ps

package sdas_pkg;

  localparam int HW_KEYS    = 16;
  localparam int KEY_W      = 4;
  localparam int CNT_W      = 5;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PRIO_W     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PRIORITIES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_CONV0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_CONV1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STALENESS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STALENESS  = 3'd5;

  // key priority codes
  localparam logic [PRIO_W-1:0] PRIO_SLOW     = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_RELAXED  = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_CRITICAL = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_NEVER    = 2'd3;

  // request types
  localparam logic REQ_ROUND  = 1'b0;
  localparam logic REQ_RECORD = 1'b1;

  // commands from the controller
  typedef struct packed {
    logic record;     // store a sample time
    logic start;      // open a round: latch time, empty stacks
    logic age_step;   // compute age of the current key
    logic eval_step;  // classify and push the current key, advance
    logic emit;       // pop one pair into the output register
  } ctl_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic n_zero;     // no keys in use
    logic scan_last;  // current key is the last one of the scan
    logic out_free;   // output register can take a word this cycle
    logic pair_last;  // the pair being popped ends the round
  } dp_status_t;

endpackage

/* hw/rtl/sdas_ctrl.sv */
// Controller state machine of the scheduler: sequences record, scan and pop phases.
// Depends on sdas_pkg.
`timescale 1ns / 1ps

module sdas_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_req_type,
  output logic                  in_ready,
  input  sdas_pkg::dp_status_t  status,
  output sdas_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AGE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    cmd           = '0;
    cmd.record    = accept && (in_req_type == sdas_pkg::REQ_RECORD);
    cmd.start     = accept && (in_req_type == sdas_pkg::REQ_ROUND);
    cmd.age_step  = (state_r == ST_AGE);
    cmd.eval_step = (state_r == ST_EVAL);
    cmd.emit      = (state_r == ST_EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.start) begin
            in_ready_r <= 1'b0;
            state_r    <= status.n_zero ? ST_EMIT : ST_AGE;
          end
        end
        ST_AGE: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          state_r <= status.scan_last ? ST_EMIT : ST_AGE;
        end
        ST_EMIT: begin
          if (cmd.emit && status.pair_last) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/sdas_datapath.sv */
// Datapath of the scheduler: config registers, sample time store, three key stacks
// and the output register. Depends on sdas_pkg.
`timescale 1ns / 1ps

module sdas_datapath #(
  parameter int MAX_KEYS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [sdas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdas_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [sdas_pkg::TIME_W-1:0]         in_now_time,
  input  logic [sdas_pkg::KEY_W-1:0]          in_key_index,
  input  logic [sdas_pkg::TIME_W-1:0]         in_sample_time,
  input  sdas_pkg::ctl_cmd_t                  cmd,
  output sdas_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_conv0_valid,
  output logic [sdas_pkg::KEY_W-1:0]          out_conv0_key,
  output logic                                out_conv1_valid,
  output logic [sdas_pkg::KEY_W-1:0]          out_conv1_key,
  output logic                                out_last_pair
);

  localparam int NKEYS = (MAX_KEYS < sdas_pkg::HW_KEYS) ? MAX_KEYS : sdas_pkg::HW_KEYS;
  localparam int IW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int SD    = (NKEYS < 2) ? 2 : NKEYS;
  localparam logic [sdas_pkg::CNT_W-1:0] N_LIM = sdas_pkg::CNT_W'(NKEYS);

  typedef logic [sdas_pkg::KEY_W-1:0] key_t;
  typedef logic [sdas_pkg::CNT_W-1:0] cnt_t;
  typedef logic [sdas_pkg::TIME_W-1:0] time_t;

  // configuration
  cnt_t                    key_count_r;
  logic [31:0]             key_priorities_r;
  logic [15:0]             allowed0_r;
  logic [15:0]             allowed1_r;
  time_t                   max_stale_r;
  time_t                   min_stale_r;

  // scan state
  time_t                   sample_r [NKEYS];
  time_t                   now_r;
  time_t                   age_r;
  cnt_t                    idx_r;
  logic                    urg_r;
  logic                    urg_nxt;

  // stacks, top of stack at entry 0
  key_t                    s0_r [SD];
  key_t                    s1_r [SD];
  key_t                    sb_r [SD];
  key_t                    s0_nxt [SD];
  key_t                    s1_nxt [SD];
  key_t                    sb_nxt [SD];
  cnt_t                    c0_r, c1_r, cb_r;
  cnt_t                    c0_nxt, c1_nxt, cb_nxt;

  // output register
  logic                    out_valid_r;
  logic                    v0_r, v1_r, last_r;
  key_t                    k0_r, k1_r;

  cnt_t                    nkeys;
  key_t                    cur_key;
  logic [sdas_pkg::PRIO_W-1:0] prio;
  logic                    urgent;
  logic                    cand;
  logic                    a0, a1;

  // pair selection
  cnt_t                    c0e, c1e, cbe, cb_after;
  logic                    pop0, pop1, popb0, popb1;
  logic                    v0, v1, pair_last;
  key_t                    k0, k1;

  assign nkeys   = (key_count_r > N_LIM) ? N_LIM : key_count_r;
  assign cur_key = idx_r[sdas_pkg::KEY_W-1:0];
  assign prio    = key_priorities_r[{cur_key, 1'b0} +: sdas_pkg::PRIO_W];
  assign a0      = allowed0_r[cur_key];
  assign a1      = allowed1_r[cur_key];

  always_comb begin
    unique case (prio) inside
      sdas_pkg::PRIO_SLOW,
      sdas_pkg::PRIO_CRITICAL: urgent = 1'b1;
      sdas_pkg::PRIO_RELAXED:  urgent = age_r > max_stale_r;
      default:                 urgent = 1'b0;
    endcase
  end

  assign cand = urgent || (age_r > min_stale_r);

  // Stacks count as empty when the round found nothing urgent.
  always_comb begin
    c0e      = urg_r ? c0_r : '0;
    c1e      = urg_r ? c1_r : '0;
    cbe      = urg_r ? cb_r : '0;
    pop0     = (c0e != '0);
    popb0    = !pop0 && (cbe != '0);
    cb_after = cbe - cnt_t'(popb0);
    pop1     = (c1e != '0);
    popb1    = !pop1 && (cb_after != '0);
    v0       = pop0 || popb0;
    v1       = pop1 || popb1;
    k0       = pop0 ? s0_r[0] : (popb0 ? sb_r[0] : '0);
    k1       = pop1 ? s1_r[0] : (popb1 ? (popb0 ? sb_r[1] : sb_r[0]) : '0);
    pair_last = ((c0e - cnt_t'(pop0)) == '0) && ((c1e - cnt_t'(pop1)) == '0) &&
                ((cb_after - cnt_t'(popb1)) == '0);
  end

  always_comb begin
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    sb_nxt  = sb_r;
    c0_nxt  = c0_r;
    c1_nxt  = c1_r;
    cb_nxt  = cb_r;
    urg_nxt = urg_r;
    if (cmd.start) begin
      c0_nxt  = '0;
      c1_nxt  = '0;
      cb_nxt  = '0;
      urg_nxt = 1'b0;
    end else if (cmd.eval_step) begin
      if (urgent) urg_nxt = 1'b1;
      if (cand) begin
        if (a0 && a1) begin
          for (int i = SD - 1; i > 0; i--) sb_nxt[i] = sb_r[i-1];
          sb_nxt[0] = cur_key;
          cb_nxt    = cb_r + cnt_t'(1);
        end else if (a0) begin
          for (int i = SD - 1; i > 0; i--) s0_nxt[i] = s0_r[i-1];
          s0_nxt[0] = cur_key;
          c0_nxt    = c0_r + cnt_t'(1);
        end else if (a1) begin
          for (int i = SD - 1; i > 0; i--) s1_nxt[i] = s1_r[i-1];
          s1_nxt[0] = cur_key;
          c1_nxt    = c1_r + cnt_t'(1);
        end
      end
    end else if (cmd.emit) begin
      c0_nxt = c0e - cnt_t'(pop0);
      c1_nxt = c1e - cnt_t'(pop1);
      cb_nxt = cb_after - cnt_t'(popb1);
      if (pop0) begin
        for (int i = 0; i < SD - 1; i++) s0_nxt[i] = s0_r[i+1];
      end
      if (pop1) begin
        for (int i = 0; i < SD - 1; i++) s1_nxt[i] = s1_r[i+1];
      end
      if (popb0 && popb1) begin
        for (int i = 0; i < SD - 2; i++) sb_nxt[i] = sb_r[i+2];
      end else if (popb0 || popb1) begin
        for (int i = 0; i < SD - 1; i++) sb_nxt[i] = sb_r[i+1];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r      <= '0;
      key_priorities_r <= 32'h5555_5555;
      allowed0_r       <= '0;
      allowed1_r       <= '0;
      max_stale_r      <= 32'd1000;
      min_stale_r      <= 32'd500;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sdas_pkg::CFG_KEY_COUNT:      key_count_r      <= cfg_wdata[sdas_pkg::CNT_W-1:0];
        sdas_pkg::CFG_KEY_PRIORITIES: key_priorities_r <= cfg_wdata;
        sdas_pkg::CFG_ALLOWED_CONV0:  allowed0_r       <= cfg_wdata[15:0];
        sdas_pkg::CFG_ALLOWED_CONV1:  allowed1_r       <= cfg_wdata[15:0];
        sdas_pkg::CFG_MAX_STALENESS:  max_stale_r      <= cfg_wdata;
        sdas_pkg::CFG_MIN_STALENESS:  min_stale_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample time store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NKEYS; i++) sample_r[i] <= '0;
    end else if (cmd.record && (cnt_t'(in_key_index) < N_LIM)) begin
      sample_r[in_key_index[IW-1:0]] <= in_sample_time;
    end
  end

  // scan registers and stacks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      urg_r <= 1'b0;
      c0_r  <= '0;
      c1_r  <= '0;
      cb_r  <= '0;
    end else begin
      if (cmd.start) idx_r <= '0;
      else if (cmd.eval_step) idx_r <= idx_r + cnt_t'(1);
      urg_r <= urg_nxt;
      c0_r  <= c0_nxt;
      c1_r  <= c1_nxt;
      cb_r  <= cb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) now_r <= in_now_time;
    if (cmd.age_step) age_r <= now_r - sample_r[idx_r[IW-1:0]];
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
    sb_r <= sb_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      v0_r   <= v0;
      k0_r   <= k0;
      v1_r   <= v1;
      k1_r   <= k1;
      last_r <= pair_last;
    end
  end

  always_comb begin
    status           = '0;
    status.n_zero    = (nkeys == '0);
    status.scan_last = ((idx_r + cnt_t'(1)) == nkeys);
    status.out_free  = !out_valid_r || out_ready;
    status.pair_last = pair_last;
  end

  assign out_valid       = out_valid_r;
  assign out_conv0_valid = v0_r;
  assign out_conv0_key   = k0_r;
  assign out_conv1_valid = v1_r;
  assign out_conv1_key   = k1_r;
  assign out_last_pair   = last_r;

endmodule

/* hw/rtl/staleness_dual_adc_scheduler_top.sv */
// Staleness-driven scheduler of sensor keys onto two converters (top level).
// Record word: stores a sample time, no result. Round word over n active keys: a scan
// per key (age subtract, then classify and push), then one pair word a cycle while the
// output register has room; the input reopens when the last pair word is loaded into the
// output register. rst_n (synchronous, active low) empties the stacks,
`timescale 1ns / 1ps

// zeroes the sample times and loads the register reset values. Depends on sdas_pkg.
module staleness_dual_adc_scheduler_top #(
  parameter int MAX_KEYS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [sdas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdas_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // request words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [sdas_pkg::TIME_W-1:0]         in_now_time,
  input  logic [sdas_pkg::KEY_W-1:0]          in_key_index,
  input  logic [sdas_pkg::TIME_W-1:0]         in_sample_time,
  // pair words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_conv0_valid,
  output logic [sdas_pkg::KEY_W-1:0]          out_conv0_key,
  output logic                                out_conv1_valid,
  output logic [sdas_pkg::KEY_W-1:0]          out_conv1_key,
  output logic                                out_last_pair
);

  sdas_pkg::ctl_cmd_t   cmd;
  sdas_pkg::dp_status_t status;

  // Controller: takes request words only while idle, then walks the scan
  // and drives one pop per cycle while the output register has room.
  sdas_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // Datapath: takes each key through the age subtract and the staleness
  // compares, pushes onto the three stacks, and pops pairs with
  // converter 0 served first, the shared stack filling whichever side is short.
  sdas_datapath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_now_time     (in_now_time),
    .in_key_index    (in_key_index),
    .in_sample_time  (in_sample_time),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_conv0_valid (out_conv0_valid),
    .out_conv0_key   (out_conv0_key),
    .out_conv1_valid (out_conv1_valid),
    .out_conv1_key   (out_conv1_key),
    .out_last_pair   (out_last_pair)
  );

endmodule

/* test/tb.sv */
// Self-checking bench for staleness_dual_adc_scheduler_top: drives record and round words,
// predicts the pair words each round yields and checks them in order. Depends on sdas_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_KEYS   = 16;
  localparam int CYCLE_CAP  = 1000000;
  localparam int LONG_HOLD  = 500;
  localparam int SPAN       = 1500;

  // one request word as the block takes it
  typedef struct packed {
    logic                        req_type;
    logic [sdas_pkg::TIME_W-1:0] now_time;
    logic [sdas_pkg::KEY_W-1:0]  key_index;
    logic [sdas_pkg::TIME_W-1:0] sample_time;
  } req_word_t;

  // one pair word as the block gives it
  typedef struct packed {
    logic                       conv0_valid;
    logic [sdas_pkg::KEY_W-1:0] conv0_key;
    logic                       conv1_valid;
    logic [sdas_pkg::KEY_W-1:0] conv1_key;
    logic                       last_pair;
  } pair_t;

  // one full register setting
  typedef struct {
    logic [sdas_pkg::CNT_W-1:0]   key_count;
    logic [31:0]                  key_prio;
    logic [sdas_pkg::HW_KEYS-1:0] conv0_mask;
    logic [sdas_pkg::HW_KEYS-1:0] conv1_mask;
    logic [sdas_pkg::TIME_W-1:0]  max_stale;
    logic [sdas_pkg::TIME_W-1:0]  min_stale;
  } sched_cfg_t;

  // Scheduler predictor: own copy of the registers and sample times, and the
  // queue of pair words still owed by the block.
  class pair_board;
    logic [sdas_pkg::CNT_W-1:0]   key_count;
    logic [31:0]                  key_prio;
    logic [sdas_pkg::HW_KEYS-1:0] conv0_mask;
    logic [sdas_pkg::HW_KEYS-1:0] conv1_mask;
    logic [sdas_pkg::TIME_W-1:0]  max_stale;
    logic [sdas_pkg::TIME_W-1:0]  min_stale;
    logic [sdas_pkg::TIME_W-1:0]  sample_at [sdas_pkg::HW_KEYS];
    pair_t                        pending_pairs [$];
    int                           mismatches;

    function new();
      key_count  = '0;
      key_prio   = 32'h5555_5555;
      conv0_mask = '0;
      conv1_mask = '0;
      max_stale  = 32'd1000;
      min_stale  = 32'd500;
      foreach (sample_at[k]) sample_at[k] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [sdas_pkg::CFG_IDX_W-1:0] idx,
                          logic [sdas_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sdas_pkg::CFG_KEY_COUNT:      key_count  = val[sdas_pkg::CNT_W-1:0];
        sdas_pkg::CFG_KEY_PRIORITIES: key_prio   = val;
        sdas_pkg::CFG_ALLOWED_CONV0:  conv0_mask = val[sdas_pkg::HW_KEYS-1:0];
        sdas_pkg::CFG_ALLOWED_CONV1:  conv1_mask = val[sdas_pkg::HW_KEYS-1:0];
        sdas_pkg::CFG_MAX_STALENESS:  max_stale  = val;
        sdas_pkg::CFG_MIN_STALENESS:  min_stale  = val;
        default: ;
      endcase
    endfunction

    function bit is_due(int k, logic [sdas_pkg::TIME_W-1:0] age);
      logic [sdas_pkg::PRIO_W-1:0] p;
      p = key_prio[sdas_pkg::PRIO_W*k +: sdas_pkg::PRIO_W];
      case (p) inside
        sdas_pkg::PRIO_SLOW, sdas_pkg::PRIO_CRITICAL: return 1'b1;
        sdas_pkg::PRIO_RELAXED:                       return age > max_stale;
        default:                                      return 1'b0;
      endcase
    endfunction

    // Record words update the sample time; round words queue their pair words.
    function void note_word(req_word_t w);
      int                          n;
      bit                          any_due;
      logic [sdas_pkg::TIME_W-1:0] age;
      logic [sdas_pkg::KEY_W-1:0]  only0 [sdas_pkg::HW_KEYS];
      logic [sdas_pkg::KEY_W-1:0]  only1 [sdas_pkg::HW_KEYS];
      logic [sdas_pkg::KEY_W-1:0]  both [sdas_pkg::HW_KEYS];
      int                          n0, n1, nb;
      pair_t                       p;
      if (w.req_type == sdas_pkg::REQ_RECORD) begin
        if (w.key_index < MAX_KEYS) sample_at[w.key_index] = w.sample_time;
        return;
      end
      n = (int'(key_count) > MAX_KEYS) ? MAX_KEYS : int'(key_count);
      n0 = 0;
      n1 = 0;
      nb = 0;
      any_due = 1'b0;
      for (int k = 0; k < n; k++)
        if (is_due(k, w.now_time - sample_at[k])) any_due = 1'b1;
      if (any_due) begin
        for (int k = 0; k < n; k++) begin
          age = w.now_time - sample_at[k];
          if (!(is_due(k, age) || age > min_stale)) continue;
          if (conv0_mask[k] && conv1_mask[k]) begin
            both[nb] = k[sdas_pkg::KEY_W-1:0];
            nb++;
          end else if (conv0_mask[k]) begin
            only0[n0] = k[sdas_pkg::KEY_W-1:0];
            n0++;
          end else if (conv1_mask[k]) begin
            only1[n1] = k[sdas_pkg::KEY_W-1:0];
            n1++;
          end
        end
      end
      if (n0 == 0 && n1 == 0 && nb == 0) begin
        p = '0;
        p.last_pair = 1'b1;
        pending_pairs = {pending_pairs, p};
        return;
      end
      while (n0 != 0 || n1 != 0 || nb != 0) begin
        p = '0;
        if (n0 != 0) begin
          n0--;
          p.conv0_valid = 1'b1;
          p.conv0_key   = only0[n0];
        end else if (nb != 0) begin
          nb--;
          p.conv0_valid = 1'b1;
          p.conv0_key   = both[nb];
        end
        if (n1 != 0) begin
          n1--;
          p.conv1_valid = 1'b1;
          p.conv1_key   = only1[n1];
        end else if (nb != 0) begin
          nb--;
          p.conv1_valid = 1'b1;
          p.conv1_key   = both[nb];
        end
        p.last_pair = (n0 == 0 && n1 == 0 && nb == 0);
        pending_pairs = {pending_pairs, p};
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_pair(pair_t got);
      pair_t want;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        $display("%0t: pair word with nothing expected, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_pairs.pop_front();
      compare_field("conv0_valid", 32'(want.conv0_valid), 32'(got.conv0_valid));
      compare_field("conv0_key",   32'(want.conv0_key),   32'(got.conv0_key));
      compare_field("conv1_valid", 32'(want.conv1_valid), 32'(got.conv1_valid));
      compare_field("conv1_key",   32'(want.conv1_key),   32'(got.conv1_key));
      compare_field("last_pair",   32'(want.last_pair),   32'(got.last_pair));
    endfunction
  endclass

  // Every input starts known; all later changes are nonblocking at a rising edge.
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [sdas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sdas_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_req_type = 1'b0;
  logic [sdas_pkg::TIME_W-1:0]     in_now_time = '0;
  logic [sdas_pkg::KEY_W-1:0]      in_key_index = '0;
  logic [sdas_pkg::TIME_W-1:0]     in_sample_time = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_conv0_valid;
  logic [sdas_pkg::KEY_W-1:0]      out_conv0_key;
  logic                            out_conv1_valid;
  logic [sdas_pkg::KEY_W-1:0]      out_conv1_key;
  logic                            out_last_pair;

  pair_board                   board = new();
  bit                          send_calm = 1'b0;
  bit                          long_hold_req = 1'b0;
  logic [sdas_pkg::TIME_W-1:0] time_base = '0;
  int unsigned                 cycle_count = 0;

  staleness_dual_adc_scheduler_top #(.MAX_KEYS(MAX_KEYS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_now_time     (in_now_time),
    .in_key_index    (in_key_index),
    .in_sample_time  (in_sample_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_conv0_valid (out_conv0_valid),
    .out_conv0_key   (out_conv0_key),
    .out_conv1_valid (out_conv1_valid),
    .out_conv1_key   (out_conv1_key),
    .out_last_pair   (out_last_pair)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("staleness_dual_adc_scheduler_top verification failed");
      $finish;
    end
  end

  // Offer one request word after a random gap. Leave valid high on return so a
  // back-to-back word needs no lowering; a gap lowers it first.
  task automatic send_word(req_word_t w);
    int gap;
    if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= w.req_type;
    in_now_time    <= w.now_time;
    in_key_index   <= w.key_index;
    in_sample_time <= w.sample_time;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_word(w);
  endtask

  // Hold off the sender until every owed pair word is back, then let a
  // trailing record word settle.
  task automatic drain_pairs();
    in_valid <= 1'b0;
    while (board.pending_pairs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [sdas_pkg::CFG_IDX_W-1:0] idx,
                           logic [sdas_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // Write all six registers back to back, only once the block is idle.
  task automatic apply_cfg(sched_cfg_t c);
    drain_pairs();
    write_reg(sdas_pkg::CFG_KEY_COUNT,      sdas_pkg::CFG_DATA_W'(c.key_count));
    write_reg(sdas_pkg::CFG_KEY_PRIORITIES, c.key_prio);
    write_reg(sdas_pkg::CFG_ALLOWED_CONV0,  sdas_pkg::CFG_DATA_W'(c.conv0_mask));
    write_reg(sdas_pkg::CFG_ALLOWED_CONV1,  sdas_pkg::CFG_DATA_W'(c.conv1_mask));
    write_reg(sdas_pkg::CFG_MAX_STALENESS,  c.max_stale);
    write_reg(sdas_pkg::CFG_MIN_STALENESS,  c.min_stale);
    cfg_wr_en <= 1'b0;
  endtask

  // Unused fields of a word carry random bits; the block must ignore them.
  function automatic req_word_t record_word(logic [sdas_pkg::KEY_W-1:0] key,
                                            logic [sdas_pkg::TIME_W-1:0] t);
    req_word_t w;
    w.req_type    = sdas_pkg::REQ_RECORD;
    w.now_time    = $urandom;
    w.key_index   = key;
    w.sample_time = t;
    return w;
  endfunction

  function automatic req_word_t round_word(logic [sdas_pkg::TIME_W-1:0] t);
    req_word_t w;
    w.req_type    = sdas_pkg::REQ_ROUND;
    w.now_time    = t;
    w.key_index   = sdas_pkg::KEY_W'($urandom_range(0, 15));
    w.sample_time = $urandom;
    return w;
  endfunction

  // Mostly a coherent timeline: records a little behind the running clock,
  // rounds that advance it. The rest is raw noise across the full range.
  function automatic req_word_t make_word();
    bit is_record;
    is_record = ($urandom_range(0, 99) < 55);
    if ($urandom_range(0, 99) < 12)
      return is_record ? record_word(sdas_pkg::KEY_W'($urandom_range(0, 15)), $urandom)
                       : round_word($urandom);
    if (is_record)
      return record_word(sdas_pkg::KEY_W'($urandom_range(0, 15)),
                         time_base - $urandom_range(0, 2 * SPAN));
    time_base = time_base + $urandom_range(0, SPAN);
    return round_word(time_base);
  endfunction

  function automatic sched_cfg_t random_cfg();
    sched_cfg_t c;
    c.key_count  = ($urandom_range(0, 9) < 7) ? sdas_pkg::CNT_W'($urandom_range(12, 16))
                                              : sdas_pkg::CNT_W'($urandom_range(0, 31));
    c.key_prio   = $urandom;
    c.conv0_mask = sdas_pkg::HW_KEYS'($urandom);
    c.conv1_mask = sdas_pkg::HW_KEYS'($urandom);
    c.max_stale  = $urandom_range(0, 2 * SPAN);
    c.min_stale  = $urandom_range(0, 2 * SPAN);
    return c;
  endfunction

  // Pair sink: random stalls, stretches without any, and one long hold-off
  // on request so the block backs up into its input.
  initial begin : pair_sink
    int    stall;
    bit    calm;
    pair_t got;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 15);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.conv0_valid = out_conv0_valid;
      got.conv0_key   = out_conv0_key;
      got.conv1_valid = out_conv1_valid;
      got.conv1_key   = out_conv1_key;
      got.last_pair   = out_last_pair;
      board.check_pair(got);
    end
  end

  initial begin : request_source
    sched_cfg_t c;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no keys in use, so a round yields the empty pair.
    send_word(round_word(32'h0000_1234));

    // Mixed priorities and every allow combination; extreme times and wraparound.
    c.key_count  = 5'd16;
    c.key_prio   = 32'hE4E4_E4E4;
    c.conv0_mask = 16'h0FF0;
    c.conv1_mask = 16'h3C3C;
    c.max_stale  = 32'd1000;
    c.min_stale  = 32'd500;
    apply_cfg(c);
    send_word(record_word(4'd0, 32'h0000_0000));
    send_word(record_word(4'd15, 32'hFFFF_FFFF));
    send_word(record_word(4'd7, 32'd1234));
    send_word(record_word(4'd3, 32'h8000_0000));
    send_word(record_word(4'd9, 32'd2000));
    send_word(round_word(32'hFFFF_FFFF));
    send_word(round_word(32'h0000_0000));
    send_word(round_word(32'd1500));
    send_word(round_word(32'h8000_01F4));

    // All relaxed: fresh keys give the empty pair, even past min staleness;
    // once past max staleness every key is due.
    c.key_count  = 5'd4;
    c.key_prio   = 32'h5555_5555;
    c.conv0_mask = 16'hFFFF;
    c.conv1_mask = 16'hFFFF;
    apply_cfg(c);
    for (int k = 0; k < 4; k++)
      send_word(record_word(k[sdas_pkg::KEY_W-1:0], 32'd5000));
    send_word(round_word(32'd5400));
    send_word(round_word(32'd5700));
    send_word(round_word(32'd6001));

    // Count above the key limit, all critical, none allowed: due keys all dropped.
    c.key_count  = 5'd31;
    c.key_prio   = 32'hAAAA_AAAA;
    c.conv0_mask = 16'h0000;
    c.conv1_mask = 16'h0000;
    c.max_stale  = 32'h0000_0000;
    c.min_stale  = 32'hFFFF_FFFF;
    apply_cfg(c);
    send_word(round_word(32'hDEAD_BEEF));

    // One slow key opens the round; never-due keys still ride along when stale.
    c.key_count  = 5'd16;
    c.key_prio   = 32'hFFFF_FFFC;
    c.conv0_mask = 16'hFFFF;
    c.conv1_mask = 16'h0000;
    c.max_stale  = 32'hFFFF_FFFF;
    c.min_stale  = 32'h0000_0000;
    apply_cfg(c);
    send_word(round_word(32'h0000_2000));

    // No keys in use at all.
    c.key_count = 5'd0;
    apply_cfg(c);
    send_word(round_word(32'h0000_3000));

    // Random phases, the first two at the threshold extremes.
    for (int ph = 0; ph < 8; ph++) begin
      c = random_cfg();
      if (ph == 0) begin
        c.key_count  = 5'd16;
        c.max_stale  = 32'h0000_0000;
        c.min_stale  = 32'h0000_0000;
        c.conv0_mask = 16'hFFFF;
        c.conv1_mask = 16'hFFFF;
      end
      if (ph == 1) begin
        c.key_count  = 5'd31;
        c.max_stale  = 32'hFFFF_FFFF;
        c.min_stale  = 32'hFFFF_FFFF;
        c.conv0_mask = 16'h0000;
        c.conv1_mask = 16'hFFFF;
      end
      apply_cfg(c);
      time_base = $urandom;
      for (int i = 0; i < 60; i++) begin
        // keep offering words while the sink sits out a long stretch
        if (ph == 3 && i == 10) long_hold_req = 1'b1;
        send_word(make_word());
      end
    end

    // Drain, then give the block time to show any stray pair word.
    in_valid <= 1'b0;
    while (board.pending_pairs.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("staleness_dual_adc_scheduler_top verification clean");
    end else begin
      $display("staleness_dual_adc_scheduler_top verification failed");
    end
    $finish;
  end

endmodule
